// File: rtl/kpc_pkg.sv
package kpc_pkg;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DIV,
        ST_OUT
    } t_state;

    // entry phases of the calculator
    typedef enum logic [2:0] {
        PH_A_FIRST,
        PH_A_SECOND,
        PH_OPER,
        PH_B_FIRST,
        PH_B_SECOND,
        PH_EQUALS,
        PH_SHOW,
        PH_DIV_ERR
    } t_phase;

    // operator codes, in key order A to D
    typedef enum logic [1:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV
    } t_opcode;

    // key codes
    localparam logic [3:0] KEY_DIGIT_MAX = 4'h9;
    localparam logic [3:0] KEY_OP_A      = 4'hA;
    localparam logic [3:0] KEY_OP_D      = 4'hD;
    localparam logic [3:0] KEY_STAR      = 4'hE;
    localparam logic [3:0] KEY_HASH      = 4'hF;

    // item kinds
    localparam logic CMD_KEY  = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // configuration register indexes
    localparam logic CFG_LIMIT = 1'b0;
    localparam logic CFG_BLINK = 1'b1;

    // configuration reset values
    localparam logic [6:0] LIMIT_RST = 7'd99;
    localparam logic [7:0] BLINK_RST = 8'd5;

    // led patterns
    localparam logic [7:0] LED_DARK    = 8'h00;
    localparam logic [7:0] LED_A_DIGIT = 8'h01;
    localparam logic [7:0] LED_B       = 8'h02;
    localparam logic [7:0] LED_OPER    = 8'h04;
    localparam logic [6:0] MAG_CAP     = 7'h7F;

    // restoring divider, one quotient bit per cycle
    localparam int         DIV_STEPS = 7;
    localparam logic [2:0] DIV_LAST  = 3'(DIV_STEPS - 1);

    // controller to datapath commands
    typedef struct packed {
        logic capture;
        logic execute;
        logic div_run;
        logic out_load;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic div_req;
        logic div_last;
    } t_dp_sts;

endpackage

// File: rtl/keypad_two_operand_calculator_top.sv
// Keypad two-operand calculator.
// Input channel (i_valid / o_stall) carries one transaction per key press or
// blink tick: i_cmd selects key or tick, i_key holds the key code.
// Output channel (o_valid / i_stall) returns exactly one transaction per
// input: led pattern, entry phase, divide error flag, answer, sign flag.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_idx
// (0 operand limit, 1 blink period), taken at once; the user must write
// only while idle, which the block itself does not enforce. A result passes
// through the execute and output states, a divide also through a 7-step
// restoring divider that forms one quotient bit per cycle. One transaction
// is in flight at a time: no input is taken until the last result is loaded.
// o_stall is high from acceptance until the result sits in the output
// register; while the receiver stalls a full output register, the block
// holds the next result and keeps o_stall high.
// Synchronous reset (i_rst_n low) empties the output register, returns the
// calculator to awaiting operand A and restores the register defaults.
module keypad_two_operand_calculator_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [7:0]        i_cfg_data,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic              i_cmd,
    input  logic [3:0]        i_key,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [7:0]        o_led,
    output logic [2:0]        o_phase,
    output logic              o_div_zero,
    output logic signed [8:0] o_answer,
    output logic              o_neg_shown
);

    kpc_pkg::t_dp_cmd dp_ctl;
    kpc_pkg::t_dp_sts dp_sts;

    // sequencing of each transaction
    kpc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stall (i_stall),
        .i_sts   (dp_sts),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .o_ctl   (dp_ctl)
    );

    // calculator state, divider and output register
    kpc_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (i_cmd),
        .i_key       (i_key),
        .i_ctl       (dp_ctl),
        .o_sts       (dp_sts),
        .o_led       (o_led),
        .o_phase     (o_phase),
        .o_div_zero  (o_div_zero),
        .o_answer    (o_answer),
        .o_neg_shown (o_neg_shown)
    );

endmodule

// File: rtl/kpc_ctrl.sv
module kpc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_stall,
    input  kpc_pkg::t_dp_sts  i_sts,
    output logic              o_stall,
    output logic              o_valid,
    output kpc_pkg::t_dp_cmd  o_ctl
);

    kpc_pkg::t_state r_state;
    kpc_pkg::t_state n_state;
    logic            r_out_valid;
    logic            out_free;

    // output slot can take a new transaction
    assign out_free = !r_out_valid || !i_stall;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            kpc_pkg::ST_IDLE: begin
                if (i_valid) n_state = kpc_pkg::ST_EXEC;
            end
            kpc_pkg::ST_EXEC: begin
                n_state = i_sts.div_req ? kpc_pkg::ST_DIV : kpc_pkg::ST_OUT;
            end
            kpc_pkg::ST_DIV: begin
                if (i_sts.div_last) n_state = kpc_pkg::ST_OUT;
            end
            kpc_pkg::ST_OUT: begin
                if (out_free) n_state = kpc_pkg::ST_IDLE;
            end
            default: begin
                n_state = kpc_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath commands
    always_comb begin
        o_ctl = '0;
        case (r_state)
            kpc_pkg::ST_IDLE: o_ctl.capture  = i_valid;
            kpc_pkg::ST_EXEC: o_ctl.execute  = 1'b1;
            kpc_pkg::ST_DIV:  o_ctl.div_run  = 1'b1;
            kpc_pkg::ST_OUT:  o_ctl.out_load = out_free;
            default:          o_ctl = '0;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= kpc_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // output valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_ctl.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_stall = (r_state != kpc_pkg::ST_IDLE);
    assign o_valid = r_out_valid;

    // accepted transaction is executed in the next cycle
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> (r_state == kpc_pkg::ST_EXEC))
        else $error("accepted transaction not executed");

    // last divide step hands over to the output stage
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == kpc_pkg::ST_DIV && i_sts.div_last) |=> (r_state == kpc_pkg::ST_OUT))
        else $error("divide did not finish into output stage");

    // a stalled full output slot holds the pending result back
    a_out_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == kpc_pkg::ST_OUT && r_out_valid && i_stall)
        |=> (r_state == kpc_pkg::ST_OUT && r_out_valid))
        else $error("result overwrote a stalled output");

    // output is loaded only from the output stage
    a_load_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == kpc_pkg::ST_OUT))
        else $error("output loaded outside the output stage");

endmodule

// File: rtl/kpc_dp.sv
module kpc_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [7:0]        i_cfg_data,
    input  logic              i_cmd,
    input  logic [3:0]        i_key,
    input  kpc_pkg::t_dp_cmd  i_ctl,
    output kpc_pkg::t_dp_sts  o_sts,
    output logic [7:0]        o_led,
    output logic [2:0]        o_phase,
    output logic              o_div_zero,
    output logic signed [8:0] o_answer,
    output logic              o_neg_shown
);

    // configuration
    logic [6:0]        r_limit;
    logic [7:0]        r_blink;

    // captured transaction
    logic              r_cmd;
    logic [3:0]        r_key;

    // calculator state
    kpc_pkg::t_phase   r_phase,  n_phase;
    logic [3:0]        r_first,  n_first;
    logic [6:0]        r_a,      n_a;
    logic [6:0]        r_b,      n_b;
    kpc_pkg::t_opcode  r_op,     n_op;
    logic signed [8:0] r_result, n_result;
    logic [7:0]        r_tick,   n_tick;
    logic              r_sign,   n_sign;

    // divider
    logic [6:0]        r_rem;
    logic [6:0]        r_quo;
    logic [2:0]        r_div_cnt;
    logic [7:0]        div_sh;
    logic              div_ge;
    logic [6:0]        div_rem_n;
    logic [6:0]        div_quo_n;

    // output registers
    logic [7:0]        r_led;
    logic [2:0]        r_phase_out;
    logic              r_div_zero;
    logic signed [8:0] r_answer;
    logic              r_neg;

    // decode and arithmetic helpers
    logic              key_digit;
    logic              key_oper;
    logic [7:0]        two_dig;
    logic [6:0]        two_dig_clamp;
    logic [13:0]       prod;
    logic [6:0]        prod_clamp;
    logic [7:0]        tick_inc;
    logic [7:0]        view_led;
    logic [8:0]        neg_mag;
    logic [6:0]        neg_cap;

    assign key_digit = (r_key <= kpc_pkg::KEY_DIGIT_MAX);
    assign key_oper  = (r_key >= kpc_pkg::KEY_OP_A) && (r_key <= kpc_pkg::KEY_OP_D);

    // two digit operand, clamped to the limit
    assign two_dig       = ({4'b0, r_first} * 8'd10) + {4'b0, r_key};
    assign two_dig_clamp = (two_dig > {1'b0, r_limit}) ? r_limit : two_dig[6:0];

    // product, clamped to the limit
    assign prod       = {7'b0, r_a} * {7'b0, r_b};
    assign prod_clamp = (prod > {7'b0, r_limit}) ? r_limit : prod[6:0];

    assign tick_inc = r_tick + 8'd1;

    // divide needed: hash with divide pending and nonzero divisor
    assign o_sts.div_req = (r_cmd == kpc_pkg::CMD_KEY) && (r_key == kpc_pkg::KEY_HASH)
                        && (r_phase == kpc_pkg::PH_EQUALS) && (r_op == kpc_pkg::OP_DIV)
                        && (r_b != 7'd0);
    assign o_sts.div_last = (r_div_cnt == kpc_pkg::DIV_LAST);

    // one restoring divide step
    assign div_sh    = {r_rem, r_quo[6]};
    assign div_ge    = (div_sh >= {1'b0, r_b});
    assign div_rem_n = div_ge ? 7'(div_sh - {1'b0, r_b}) : div_sh[6:0];
    assign div_quo_n = {r_quo[5:0], div_ge};

    // next calculator state for one transaction
    always_comb begin
        n_phase  = r_phase;
        n_first  = r_first;
        n_a      = r_a;
        n_b      = r_b;
        n_op     = r_op;
        n_result = r_result;
        n_tick   = r_tick;
        n_sign   = r_sign;
        if (r_cmd == kpc_pkg::CMD_TICK) begin
            // blink only while a negative answer is shown
            if (r_phase == kpc_pkg::PH_SHOW && r_result[8]) begin
                if (tick_inc >= r_blink) begin
                    n_sign = ~r_sign;
                    n_tick = 8'd0;
                end else begin
                    n_tick = tick_inc;
                end
            end
        end else if (r_key == kpc_pkg::KEY_STAR) begin
            n_phase  = kpc_pkg::PH_A_FIRST;
            n_first  = 4'd0;
            n_a      = 7'd0;
            n_b      = 7'd0;
            n_op     = kpc_pkg::OP_ADD;
            n_result = 9'sd0;
            n_tick   = 8'd0;
            n_sign   = 1'b0;
        end else begin
            case (r_phase)
                kpc_pkg::PH_A_FIRST: begin
                    if (key_digit) begin
                        n_first = r_key;
                        n_phase = kpc_pkg::PH_A_SECOND;
                    end
                end
                kpc_pkg::PH_A_SECOND: begin
                    if (key_digit) begin
                        n_a     = two_dig_clamp;
                        n_phase = kpc_pkg::PH_OPER;
                    end else if (key_oper) begin
                        n_a     = {3'b0, r_first};
                        n_op    = kpc_pkg::t_opcode'(2'(r_key - kpc_pkg::KEY_OP_A));
                        n_phase = kpc_pkg::PH_B_FIRST;
                    end else if (r_key == kpc_pkg::KEY_HASH) begin
                        n_a     = {3'b0, r_first};
                        n_phase = kpc_pkg::PH_OPER;
                    end
                end
                kpc_pkg::PH_OPER: begin
                    if (key_oper) begin
                        n_op    = kpc_pkg::t_opcode'(2'(r_key - kpc_pkg::KEY_OP_A));
                        n_phase = kpc_pkg::PH_B_FIRST;
                    end
                end
                kpc_pkg::PH_B_FIRST: begin
                    if (key_digit) begin
                        n_first = r_key;
                        n_phase = kpc_pkg::PH_B_SECOND;
                    end
                end
                kpc_pkg::PH_B_SECOND: begin
                    if (key_digit) begin
                        n_b     = two_dig_clamp;
                        n_phase = kpc_pkg::PH_EQUALS;
                    end else if (r_key == kpc_pkg::KEY_HASH) begin
                        n_b     = {3'b0, r_first};
                        n_phase = kpc_pkg::PH_EQUALS;
                    end
                end
                kpc_pkg::PH_EQUALS: begin
                    if (r_key == kpc_pkg::KEY_HASH) begin
                        case (r_op)
                            kpc_pkg::OP_ADD: begin
                                n_result = $signed({2'b0, r_a} + {2'b0, r_b});
                                n_tick   = 8'd0;
                                n_sign   = 1'b0;
                                n_phase  = kpc_pkg::PH_SHOW;
                            end
                            kpc_pkg::OP_SUB: begin
                                n_result = $signed({2'b0, r_a} - {2'b0, r_b});
                                n_tick   = 8'd0;
                                n_sign   = 1'b0;
                                n_phase  = kpc_pkg::PH_SHOW;
                            end
                            kpc_pkg::OP_MUL: begin
                                n_result = $signed({2'b0, prod_clamp});
                                n_tick   = 8'd0;
                                n_sign   = 1'b0;
                                n_phase  = kpc_pkg::PH_SHOW;
                            end
                            default: begin
                                // nonzero divisor goes through the divider
                                if (r_b == 7'd0) begin
                                    n_result = 9'sd0;
                                    n_phase  = kpc_pkg::PH_DIV_ERR;
                                end
                            end
                        endcase
                    end
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end
    end

    // led pattern of the current state
    assign neg_mag = 9'(-r_result);
    assign neg_cap = (neg_mag > {2'b0, kpc_pkg::MAG_CAP}) ? kpc_pkg::MAG_CAP : neg_mag[6:0];

    always_comb begin
        case (r_phase)
            kpc_pkg::PH_A_SECOND: view_led = kpc_pkg::LED_A_DIGIT;
            kpc_pkg::PH_OPER:     view_led = kpc_pkg::LED_OPER;
            kpc_pkg::PH_B_FIRST,
            kpc_pkg::PH_B_SECOND,
            kpc_pkg::PH_EQUALS:   view_led = kpc_pkg::LED_B;
            kpc_pkg::PH_SHOW: begin
                // a non-negative 9-bit answer never exceeds 0xFF
                view_led = r_result[8] ? {r_sign, neg_cap} : r_result[7:0];
            end
            default:              view_led = kpc_pkg::LED_DARK;
        endcase
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= kpc_pkg::LIMIT_RST;
            r_blink <= kpc_pkg::BLINK_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                kpc_pkg::CFG_LIMIT: r_limit <= i_cfg_data[6:0];
                kpc_pkg::CFG_BLINK: r_blink <= i_cfg_data;
                default:            r_blink <= r_blink;
            endcase
        end
    end

    // transaction capture
    always_ff @(posedge i_clk) begin
        if (i_ctl.capture) begin
            r_cmd <= i_cmd;
            r_key <= i_key;
        end
    end

    // calculator state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= kpc_pkg::PH_A_FIRST;
            r_first  <= 4'd0;
            r_a      <= 7'd0;
            r_b      <= 7'd0;
            r_op     <= kpc_pkg::OP_ADD;
            r_result <= 9'sd0;
            r_tick   <= 8'd0;
            r_sign   <= 1'b0;
        end else if (i_ctl.execute) begin
            r_phase  <= n_phase;
            r_first  <= n_first;
            r_a      <= n_a;
            r_b      <= n_b;
            r_op     <= n_op;
            r_result <= n_result;
            r_tick   <= n_tick;
            r_sign   <= n_sign;
        end else if (i_ctl.div_run && o_sts.div_last) begin
            r_result <= $signed({2'b0, div_quo_n});
            r_tick   <= 8'd0;
            r_sign   <= 1'b0;
            r_phase  <= kpc_pkg::PH_SHOW;
        end
    end

    // divider registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_cnt <= 3'd0;
        end else if (i_ctl.execute) begin
            r_div_cnt <= 3'd0;
        end else if (i_ctl.div_run) begin
            r_div_cnt <= r_div_cnt + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.execute) begin
            r_rem <= 7'd0;
            r_quo <= r_a;
        end else if (i_ctl.div_run) begin
            r_rem <= div_rem_n;
            r_quo <= div_quo_n;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (i_ctl.out_load) begin
            r_led       <= view_led;
            r_phase_out <= r_phase;
            r_div_zero  <= (r_phase == kpc_pkg::PH_DIV_ERR);
            r_answer    <= (r_phase == kpc_pkg::PH_SHOW) ? r_result : 9'sd0;
            r_neg       <= (r_phase == kpc_pkg::PH_SHOW) && r_result[8];
        end
    end

    assign o_led       = r_led;
    assign o_phase     = r_phase_out;
    assign o_div_zero  = r_div_zero;
    assign o_answer    = r_answer;
    assign o_neg_shown = r_neg;

endmodule

// File: tb/tb_keypad_two_operand_calculator_top.sv
module tb_keypad_two_operand_calculator_top;

    timeunit 1ns;
    timeprecision 1ps;

    // operator keys by operation
    localparam logic [3:0] KEY_ADD = kpc_pkg::KEY_OP_A;
    localparam logic [3:0] KEY_SUB = kpc_pkg::KEY_OP_A + 4'd1;
    localparam logic [3:0] KEY_MUL = kpc_pkg::KEY_OP_A + 4'd2;
    localparam logic [3:0] KEY_DIV = kpc_pkg::KEY_OP_D;

    localparam int HOLD_CYCLES  = 400;
    localparam int PHASE_ITEMS  = 195;
    localparam int DRAIN_CYCLES = 20;

    // one display transaction
    typedef struct packed {
        logic [7:0]        led;
        kpc_pkg::t_phase   phase;
        logic              div_zero;
        logic signed [8:0] answer;
        logic              neg_shown;
    } t_display;

    // one row of the directed stimulus
    typedef struct packed {
        logic       cmd;
        logic [3:0] key;
        logic       typed;
        t_display   want;
    } t_row;

    localparam t_display NO_WANT =
        '{kpc_pkg::LED_DARK, kpc_pkg::PH_A_FIRST, 1'b0, 9'sd0, 1'b0};
    localparam t_display SHOW_DARK =
        '{kpc_pkg::LED_DARK, kpc_pkg::PH_A_FIRST, 1'b0, 9'sd0, 1'b0};

    // directed stimulus: literal expectations only where obvious
    localparam int DIR_LEN = 27;
    localparam t_row DIR_ROWS [DIR_LEN] = '{
        '{kpc_pkg::CMD_TICK, 4'd0,     1'b1, SHOW_DARK},
        '{kpc_pkg::CMD_KEY,  4'd9,     1'b1,
          '{kpc_pkg::LED_A_DIGIT, kpc_pkg::PH_A_SECOND, 1'b0, 9'sd0, 1'b0}},
        '{kpc_pkg::CMD_KEY,  4'd9,     1'b1,
          '{kpc_pkg::LED_OPER, kpc_pkg::PH_OPER, 1'b0, 9'sd0, 1'b0}},
        '{kpc_pkg::CMD_KEY,  KEY_MUL,  1'b1,
          '{kpc_pkg::LED_B, kpc_pkg::PH_B_FIRST, 1'b0, 9'sd0, 1'b0}},
        '{kpc_pkg::CMD_KEY,  4'd9,     1'b0, NO_WANT},
        '{kpc_pkg::CMD_KEY,  4'd9,     1'b0, NO_WANT},
        '{kpc_pkg::CMD_KEY,  kpc_pkg::KEY_HASH, 1'b1,
          '{8'h63, kpc_pkg::PH_SHOW, 1'b0, 9'sd99, 1'b0}},
        '{kpc_pkg::CMD_KEY,  4'd1,     1'b0, NO_WANT},
        '{kpc_pkg::CMD_KEY,  kpc_pkg::KEY_STAR, 1'b1, SHOW_DARK},
        '{kpc_pkg::CMD_KEY,  4'd0,     1'b0, NO_WANT},
        '{kpc_pkg::CMD_KEY,  KEY_SUB,  1'b0, NO_WANT},
        '{kpc_pkg::CMD_KEY,  4'd9,     1'b0, NO_WANT},
        '{kpc_pkg::CMD_KEY,  kpc_pkg::KEY_HASH, 1'b0, NO_WANT},
        '{kpc_pkg::CMD_KEY,  kpc_pkg::KEY_HASH, 1'b1,
          '{8'h09, kpc_pkg::PH_SHOW, 1'b0, -9'sd9, 1'b1}},
        '{kpc_pkg::CMD_TICK, 4'd15,    1'b1,
          '{8'h89, kpc_pkg::PH_SHOW, 1'b0, -9'sd9, 1'b1}},
        '{kpc_pkg::CMD_TICK, 4'd0,     1'b0, NO_WANT},
        '{kpc_pkg::CMD_KEY,  kpc_pkg::KEY_STAR, 1'b0, NO_WANT},
        '{kpc_pkg::CMD_KEY,  4'd5,     1'b0, NO_WANT},
        '{kpc_pkg::CMD_KEY,  KEY_DIV,  1'b0, NO_WANT},
        '{kpc_pkg::CMD_KEY,  4'd0,     1'b0, NO_WANT},
        '{kpc_pkg::CMD_KEY,  kpc_pkg::KEY_HASH, 1'b0, NO_WANT},
        '{kpc_pkg::CMD_KEY,  kpc_pkg::KEY_HASH, 1'b1,
          '{kpc_pkg::LED_DARK, kpc_pkg::PH_DIV_ERR, 1'b1, 9'sd0, 1'b0}},
        '{kpc_pkg::CMD_KEY,  kpc_pkg::KEY_STAR, 1'b0, NO_WANT},
        '{kpc_pkg::CMD_KEY,  4'd1,     1'b0, NO_WANT},
        '{kpc_pkg::CMD_KEY,  KEY_ADD,  1'b0, NO_WANT},
        '{kpc_pkg::CMD_KEY,  4'd2,     1'b0, NO_WANT},
        '{kpc_pkg::CMD_KEY,  kpc_pkg::KEY_HASH, 1'b0, NO_WANT}
    };

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic              i_cfg_idx = kpc_pkg::CFG_LIMIT;
    logic [7:0]        i_cfg_data = '0;
    logic              i_valid = 1'b0;
    logic              o_stall;
    logic              i_cmd = kpc_pkg::CMD_KEY;
    logic [3:0]        i_key = '0;
    logic              o_valid;
    logic              i_stall = 1'b0;
    logic [7:0]        o_led;
    logic [2:0]        o_phase;
    logic              o_div_zero;
    logic signed [8:0] o_answer;
    logic              o_neg_shown;

    // calculator shadow state and register copies
    kpc_pkg::t_phase  calc_phase;
    logic [3:0]       calc_first;
    logic [6:0]       calc_a;
    logic [6:0]       calc_b;
    kpc_pkg::t_opcode calc_op;
    int               calc_result;
    logic [7:0]       calc_ticks;
    logic             calc_sign;
    logic [6:0]       cfg_limit;
    logic [7:0]       cfg_blink;

    t_display displays_due [$];
    int       errors = 0;
    int       items_sent = 0;

    // receiver pacing; the sender sets no_idle and hold_requests nonblocking
    logic no_idle = 1'b0;
    int   hold_requests = 0;
    int   holds_served = 0;
    int   hold_left = 0;

    keypad_two_operand_calculator_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_cmd       (i_cmd),
        .i_key       (i_key),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_led       (o_led),
        .o_phase     (o_phase),
        .o_div_zero  (o_div_zero),
        .o_answer    (o_answer),
        .o_neg_shown (o_neg_shown)
    );

    always #6 i_clk = ~i_clk;

    // two-digit operand with clamp
    function automatic logic [6:0] clamp_pair(input logic [3:0] hi, input logic [3:0] lo);
        int v;
        v = int'(hi) * 10 + int'(lo);
        return (v > int'(cfg_limit)) ? cfg_limit : 7'(v);
    endfunction

    function automatic void calc_clear();
        calc_phase  = kpc_pkg::PH_A_FIRST;
        calc_first  = '0;
        calc_a      = '0;
        calc_b      = '0;
        calc_op     = kpc_pkg::OP_ADD;
        calc_result = 0;
        calc_ticks  = '0;
        calc_sign   = 1'b0;
    endfunction

    // advance the shadow calculator by one transaction and form its display
    task automatic calc_step(input logic cmd, input logic [3:0] key, output t_display d);
        logic is_digit;
        logic is_oper;
        int   opa;
        int   opb;
        int   mag;
        is_digit = key <= kpc_pkg::KEY_DIGIT_MAX;
        is_oper  = key >= kpc_pkg::KEY_OP_A && key <= kpc_pkg::KEY_OP_D;
        opa = int'(calc_a);
        opb = int'(calc_b);
        if (cmd == kpc_pkg::CMD_KEY) begin
            if (key == kpc_pkg::KEY_STAR) begin
                calc_clear();
            end else begin
                case (calc_phase)
                    kpc_pkg::PH_A_FIRST: begin
                        if (is_digit) begin
                            calc_first = key;
                            calc_phase = kpc_pkg::PH_A_SECOND;
                        end
                    end
                    kpc_pkg::PH_A_SECOND: begin
                        if (is_digit) begin
                            calc_a     = clamp_pair(calc_first, key);
                            calc_phase = kpc_pkg::PH_OPER;
                        end else if (is_oper) begin
                            calc_a     = 7'(calc_first);
                            calc_op    = kpc_pkg::t_opcode'(2'(key - kpc_pkg::KEY_OP_A));
                            calc_phase = kpc_pkg::PH_B_FIRST;
                        end else if (key == kpc_pkg::KEY_HASH) begin
                            calc_a     = 7'(calc_first);
                            calc_phase = kpc_pkg::PH_OPER;
                        end
                    end
                    kpc_pkg::PH_OPER: begin
                        if (is_oper) begin
                            calc_op    = kpc_pkg::t_opcode'(2'(key - kpc_pkg::KEY_OP_A));
                            calc_phase = kpc_pkg::PH_B_FIRST;
                        end
                    end
                    kpc_pkg::PH_B_FIRST: begin
                        if (is_digit) begin
                            calc_first = key;
                            calc_phase = kpc_pkg::PH_B_SECOND;
                        end
                    end
                    kpc_pkg::PH_B_SECOND: begin
                        if (is_digit) begin
                            calc_b     = clamp_pair(calc_first, key);
                            calc_phase = kpc_pkg::PH_EQUALS;
                        end else if (key == kpc_pkg::KEY_HASH) begin
                            calc_b     = 7'(calc_first);
                            calc_phase = kpc_pkg::PH_EQUALS;
                        end
                    end
                    kpc_pkg::PH_EQUALS: begin
                        if (key == kpc_pkg::KEY_HASH) begin
                            if (calc_op == kpc_pkg::OP_DIV && opb == 0) begin
                                calc_result = 0;
                                calc_phase  = kpc_pkg::PH_DIV_ERR;
                            end else begin
                                case (calc_op)
                                    kpc_pkg::OP_ADD: calc_result = opa + opb;
                                    kpc_pkg::OP_SUB: calc_result = opa - opb;
                                    kpc_pkg::OP_MUL: begin
                                        calc_result = opa * opb;
                                        if (calc_result > int'(cfg_limit))
                                            calc_result = int'(cfg_limit);
                                    end
                                    default: calc_result = opa / opb;
                                endcase
                                calc_ticks = '0;
                                calc_sign  = 1'b0;
                                calc_phase = kpc_pkg::PH_SHOW;
                            end
                        end
                    end
                    default: ;
                endcase
            end
        end else if (calc_phase == kpc_pkg::PH_SHOW && calc_result < 0) begin
            // blink tick on a negative answer
            calc_ticks = calc_ticks + 8'd1;
            if (calc_ticks >= cfg_blink) begin
                calc_sign  = ~calc_sign;
                calc_ticks = '0;
            end
        end

        // led pattern for the new phase
        case (calc_phase)
            kpc_pkg::PH_A_SECOND: d.led = kpc_pkg::LED_A_DIGIT;
            kpc_pkg::PH_OPER:     d.led = kpc_pkg::LED_OPER;
            kpc_pkg::PH_B_FIRST,
            kpc_pkg::PH_B_SECOND,
            kpc_pkg::PH_EQUALS:   d.led = kpc_pkg::LED_B;
            kpc_pkg::PH_SHOW: begin
                if (calc_result < 0) begin
                    mag = -calc_result;
                    if (mag > int'(kpc_pkg::MAG_CAP)) mag = int'(kpc_pkg::MAG_CAP);
                    d.led = {calc_sign, 7'(mag)};
                end else begin
                    d.led = (calc_result > 255) ? 8'hFF : 8'(calc_result);
                end
            end
            default: d.led = kpc_pkg::LED_DARK;
        endcase
        d.phase     = calc_phase;
        d.div_zero  = calc_phase == kpc_pkg::PH_DIV_ERR;
        d.answer    = (calc_phase == kpc_pkg::PH_SHOW) ? 9'(calc_result) : 9'sd0;
        d.neg_shown = calc_phase == kpc_pkg::PH_SHOW && calc_result < 0;
    endtask

    // offer one transaction, record its expected display once accepted
    task automatic send_item(input logic cmd, input logic [3:0] key,
                             input logic typed = 1'b0, input t_display want = NO_WANT);
        t_display d;
        i_valid <= 1'b1;
        i_cmd   <= cmd;
        i_key   <= key;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        calc_step(cmd, key, d);
        displays_due.push_back(typed ? want : d);
        items_sent++;
        if (!no_idle && $urandom_range(99) < 14) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge i_clk);
        end
    endtask

    // a key press, sometimes preceded by noise or a stray star
    task automatic send_key(input logic [3:0] key);
        if ($urandom_range(99) < 8)
            send_item(1'($urandom), 4'($urandom));
        if ($urandom_range(99) < 2)
            send_item(kpc_pkg::CMD_KEY, kpc_pkg::KEY_STAR);
        send_item(kpc_pkg::CMD_KEY, key);
    endtask

    function automatic logic [3:0] pick_digit();
        int r;
        r = $urandom_range(99);
        if (r < 15) return 4'd0;
        if (r < 25) return kpc_pkg::KEY_DIGIT_MAX;
        return 4'($urandom_range(9));
    endfunction

    function automatic logic [3:0] pick_oper();
        return kpc_pkg::KEY_OP_A + 4'($urandom_range(3));
    endfunction

    // a well-formed expression with random content, blink ticks, then star
    task automatic send_expression();
        int n_ticks;
        send_key(pick_digit());
        case ($urandom_range(2))
            0: begin
                send_key(pick_digit());
                send_key(pick_oper());
            end
            1: begin
                send_key(kpc_pkg::KEY_HASH);
                send_key(pick_oper());
            end
            default: send_key(pick_oper());
        endcase
        send_key(pick_digit());
        if ($urandom_range(1))
            send_key(pick_digit());
        else
            send_key(kpc_pkg::KEY_HASH);
        send_key(kpc_pkg::KEY_HASH);
        n_ticks = $urandom_range(12);
        repeat (n_ticks) send_item(kpc_pkg::CMD_TICK, 4'($urandom));
        send_key(kpc_pkg::KEY_STAR);
    endtask

    // stop offering and let every expected display arrive
    task automatic wait_drained();
        i_valid <= 1'b0;
        while (displays_due.size() != 0) @(posedge i_clk);
    endtask

    // write both registers back to back while idle
    task automatic write_pair(input logic [6:0] limit, input logic [7:0] blink);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= kpc_pkg::CFG_LIMIT;
        i_cfg_data <= {1'b0, limit};
        @(posedge i_clk);
        cfg_limit = limit;
        i_cfg_idx  <= kpc_pkg::CFG_BLINK;
        i_cfg_data <= blink;
        @(posedge i_clk);
        cfg_blink = blink;
        i_cfg_we <= 1'b0;
    endtask

    // receiver pacing: random stalls, quiet stretch, long hold-off on request
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            i_stall   <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_requests != holds_served) begin
            i_stall      <= 1'b1;
            hold_left    <= HOLD_CYCLES;
            holds_served <= holds_served + 1;
        end else begin
            i_stall <= !no_idle && ($urandom_range(99) < 14);
        end
    end

    // compare each output transaction with the oldest expectation
    always @(posedge i_clk) begin : check_display
        t_display want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (displays_due.size() == 0) begin
                $error("display transaction with nothing expected");
                errors++;
            end else begin
                want = displays_due.pop_front();
                if (o_led !== want.led) begin
                    $error("led: expected %0h, actual %0h", want.led, o_led);
                    errors++;
                end
                if (o_phase !== want.phase) begin
                    $error("phase: expected %0d, actual %0d", want.phase, o_phase);
                    errors++;
                end
                if (o_div_zero !== want.div_zero) begin
                    $error("div_zero: expected %0b, actual %0b", want.div_zero, o_div_zero);
                    errors++;
                end
                if (o_answer !== want.answer) begin
                    $error("answer: expected %0d, actual %0d", want.answer, o_answer);
                    errors++;
                end
                if (o_neg_shown !== want.neg_shown) begin
                    $error("neg_shown: expected %0b, actual %0b",
                           want.neg_shown, o_neg_shown);
                    errors++;
                end
            end
        end
    end

    // stimulus
    initial begin
        int   ph;
        int   phase_start;
        logic held;
        calc_clear();
        cfg_limit = kpc_pkg::LIMIT_RST;
        cfg_blink = kpc_pkg::BLINK_RST;
        held = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part, blink period at its minimum
        write_pair(kpc_pkg::LIMIT_RST, 8'd1);
        for (int i = 0; i < DIR_LEN; i++)
            send_item(DIR_ROWS[i].cmd, DIR_ROWS[i].key, DIR_ROWS[i].typed, DIR_ROWS[i].want);

        // random part over several register settings
        for (ph = 0; ph < 4; ph++) begin
            wait_drained();
            case (ph)
                0: write_pair(kpc_pkg::LIMIT_RST, 8'd3);
                1: write_pair(7'd0, 8'd255);
                2: write_pair(7'($urandom_range(99, 1)), 8'($urandom_range(4, 1)));
                default: write_pair(7'($urandom_range(99)), 8'($urandom_range(8, 0)));
            endcase
            no_idle <= (ph == 2);
            phase_start = items_sent;
            while (items_sent < phase_start + PHASE_ITEMS) begin
                send_expression();
                // long receiver hold-off while the sender keeps offering
                if (ph == 0 && !held && items_sent > phase_start + 50) begin
                    hold_requests <= hold_requests + 1;
                    held = 1'b1;
                end
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0)
            $display("keypad_two_operand_calculator_top: match");
        else
            $display("keypad_two_operand_calculator_top: mismatch");
        $finish;
    end

    // run time limit
    initial begin
        #5ms;
        $display("keypad_two_operand_calculator_top: mismatch");
        $finish;
    end

endmodule
